// ===== hdl/cws_pkg.sv =====
// Shared types, character codes and sizing constants for the comment and whitespace stripper.
package cws_pkg;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam int RESULT_FIFO_DEPTH = 8;

    typedef enum logic [2:0] {
        ST_LINE_START = 3'd0,
        ST_NL_PENDING = 3'd1,
        ST_COMMENT    = 3'd2,
        ST_CH_PENDING = 3'd3,
        ST_SP_PENDING = 3'd4,
        ST_SP_SKIP    = 3'd5
    } scan_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== hdl/cws_scanner.sv =====
// Input register, scan state machine and result formation for one byte per cycle.
module cws_scanner
    import cws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       in_final,
    output push_t      push
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_final_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t step_state;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic        have;
    logic [7:0]  emit;
    logic        is_eol;
    logic        is_blank;
    logic        is_hash;

    assign is_eol   = (in_byte_reg == CHAR_LF) || (in_byte_reg == CHAR_CR);
    assign is_blank = (in_byte_reg == CHAR_TAB) || (in_byte_reg == CHAR_SPACE);
    assign is_hash  = (in_byte_reg == CHAR_HASH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= ST_LINE_START;
            held_reg     <= 8'h00;
        end
        else
        begin
            in_valid_reg <= in_accept;
            state_reg    <= state_next;
            held_reg     <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg  <= in_byte;
            in_final_reg <= in_final;
        end
    end

    // Next state.
    always_comb
    begin
        unique case (state_reg)
            ST_COMMENT:
            begin
                step_state = is_eol ? ST_NL_PENDING : ST_COMMENT;
            end
            ST_CH_PENDING:
            begin
                if (is_hash)
                    step_state = ST_COMMENT;
                else if (is_eol)
                    step_state = ST_NL_PENDING;
                else if (is_blank)
                    step_state = ST_SP_PENDING;
                else
                    step_state = ST_CH_PENDING;
            end
            ST_SP_PENDING, ST_SP_SKIP:
            begin
                if (is_hash)
                    step_state = ST_COMMENT;
                else if (is_eol)
                    step_state = ST_NL_PENDING;
                else if (is_blank)
                    step_state = ST_SP_SKIP;
                else
                    step_state = ST_CH_PENDING;
            end
            default:
            begin
                if (is_hash)
                    step_state = ST_COMMENT;
                else if (is_eol || is_blank)
                    step_state = ST_LINE_START;
                else
                    step_state = ST_CH_PENDING;
            end
        endcase

        state_next = state_reg;
        held_next  = held_reg;
        if (in_valid_reg)
        begin
            state_next = in_final_reg ? ST_LINE_START : step_state;
            held_next  = in_final_reg ? 8'h00 : in_byte_reg;
        end
    end

    // Outputs: the character that the current state holds back.
    always_comb
    begin
        unique case (state_reg)
            ST_NL_PENDING:
            begin
                have = 1'b1;
                emit = CHAR_LF;
            end
            ST_CH_PENDING:
            begin
                have = 1'b1;
                emit = held_reg;
            end
            ST_SP_PENDING:
            begin
                have = 1'b1;
                emit = CHAR_SPACE;
            end
            default:
            begin
                have = 1'b0;
                emit = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        push.first  = '{data: emit, valid: have, last: 1'b0};
        push.second = '{data: in_byte_reg, valid: 1'b1, last: 1'b1};
        push.count  = 2'd0;
        if (in_valid_reg)
        begin
            if (!in_final_reg)
            begin
                push.count = {1'b0, have};
            end
            else if (step_state == ST_CH_PENDING)
            begin
                if (have)
                begin
                    push.count = 2'd2;
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = push.second;
                end
            end
            else
            begin
                push.count      = 2'd1;
                push.first.last = 1'b1;
            end
        end
    end

    a_two_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (in_valid_reg && in_final_reg && have))
        else $error("two results pushed outside a final character flush");

    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_final_reg) |=> (state_reg == ST_LINE_START && held_reg == 8'h00))
        else $error("state not returned to line start after the last byte");

    a_final_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_final_reg) |-> (push.count != 2'd0))
        else $error("last byte produced no result");

endmodule

// ===== hdl/cws_result_fifo.sv =====
// Result queue that takes up to two results per cycle and delivers one per transfer.
module cws_result_fifo
    import cws_pkg::*;
#(
    parameter int DEPTH = RESULT_FIFO_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space_ok,
    output logic    out_valid,
    output result_t out_res,
    input  logic    out_ready
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   wr_ptr_inc;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    // Room for the item in the input register and one more, two results each.
    assign space_ok  = (count_reg <= CW'(DEPTH - 4));
    assign wr_ptr_inc = wrap_inc(wr_ptr_reg);

    always_comb
    begin
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = wrap_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_inc] <= push.second;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg + CW'(push.count)) <= CW'(DEPTH))
        else $error("result queue overflow");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("queue count changed without a push or a transfer");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd0 && pop) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("transfer did not reduce the queue count");

endmodule

// ===== hdl/comment_whitespace_stripper.sv =====
// Top level of the comment and whitespace stripper with stream input and output ports.
// Results caused by a byte are formed from the scanner's input register, written into the result
// queue and then transfer out of it. Throughput: one input byte per cycle while s_tready is high;
// each byte yields at most one result except the last byte, which may yield two, and the output
// side delivers one result per cycle while m_tready is high.
// Input is held off while the result queue could not absorb two more items' results.
// Reset (rst_n, asynchronous, active low) empties the queue and returns the scanner to line start.
module comment_whitespace_stripper
    import cws_pkg::*;
#(
    parameter int FIFO_DEPTH = RESULT_FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // byte_valid
    output logic       m_tlast    // end_of_text
);

    push_t   push;
    result_t out_res;
    logic    space_ok;

    assign s_tready = space_ok;

    cws_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (s_tvalid && s_tready),
        .in_byte   (s_tdata),
        .in_final  (s_tlast),
        .push      (push)
    );

    cws_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = out_res.data;
    assign m_tuser = out_res.valid;
    assign m_tlast = out_res.last;

endmodule
